>>> rtl/core/bsst_pkg.sv
package bsst_pkg;

    localparam int MAX_COUNT = 64;
    localparam int DATA_W    = 32;
    localparam int GAP_W     = DATA_W + 1;
    localparam int CNT_W     = $clog2(MAX_COUNT + 1);
    localparam int IDX_W     = $clog2(MAX_COUNT);
    localparam int CAP_W     = 7;
    localparam int LIM_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    // register index decoded from paddr[2]
    localparam logic REG_CAPACITY = 1'b0;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_UPD   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

endpackage

>>> rtl/core/bounded_set_span_tracker_core.sv
// An added word scans the held numbers (one compare per held number through the shared subtract
// unit and the array read port), then drains, updates and loads its result; a rejected word skips
// to the result and the first word skips the scan. One word in flight at a time: the next word
// is taken only after the result loads, which waits while the result register is still full.
// Reset (synchronous, active low) clears count, min, max and the output valid, sets the best gap
// to all ones; capacity returns to 64. Stored numbers are not cleared: only entries below the count are read.
module bounded_set_span_tracker_core
    import bsst_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // input channel
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic signed [DATA_W-1:0] i_value,
    // result channel
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic                     o_status,
    output logic [CAP_W-1:0]         o_count,
    output logic                     o_span_valid,
    output logic [DATA_W-1:0]        o_shortest_span,
    output logic [DATA_W-1:0]        o_longest_span,
    // configuration
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_AW-1:0]        paddr,
    input  logic [APB_DW-1:0]        pwdata,
    output logic [APB_DW-1:0]        prdata,
    output logic                     pready
);

    logic [2:0]               r_state;
    logic [2:0]               n_state;
    logic [CAP_W-1:0]         r_cap;
    logic signed [DATA_W-1:0] r_val;
    logic [CNT_W-1:0]         r_held;
    logic [CNT_W-1:0]         r_idx;
    logic signed [DATA_W-1:0] r_rd_data;
    logic                     r_cmp_v;
    logic [GAP_W-1:0]         r_gap;
    logic signed [DATA_W-1:0] r_min;
    logic signed [DATA_W-1:0] r_max;
    logic                     r_reject;

    logic                     r_out_valid;
    logic                     r_out_status;
    logic [CAP_W-1:0]         r_out_count;
    logic                     r_out_span_valid;
    logic [DATA_W-1:0]        r_out_short;
    logic [DATA_W-1:0]        r_out_long;

    logic signed [DATA_W-1:0] mem [MAX_COUNT];

    logic                     in_acc;
    logic                     cfg_wr;
    logic [LIM_W-1:0]         cap_ext;
    logic [LIM_W-1:0]         max_ext;
    logic [LIM_W-1:0]         lim;
    logic                     full;
    logic                     val_ge;
    logic [DATA_W-1:0]        sub_a;
    logic [DATA_W-1:0]        sub_b;
    logic [DATA_W-1:0]        gap_abs;
    logic                     out_free;
    logic                     span_ok;
    logic [CNT_W+CAP_W-1:0]   count_wide;

    assign pready     = 1'b1;
    assign cfg_wr     = psel & penable & pwrite & (paddr[2] == REG_CAPACITY);
    assign prdata     = (paddr[2] == REG_CAPACITY) ? APB_DW'(r_cap) : '0;

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_acc     = i_in_valid & o_in_ready;

    // effective limit saturates at the array depth
    assign cap_ext = LIM_W'(r_cap);
    assign max_ext = LIM_W'(MAX_COUNT);
    assign lim     = (cap_ext > max_ext) ? max_ext : cap_ext;
    assign full    = (LIM_W'(r_held) >= lim);

    // shared unit: order the pair, one subtract gives the absolute gap
    assign val_ge  = (r_val >= r_rd_data);
    assign sub_a   = val_ge ? r_val : r_rd_data;
    assign sub_b   = val_ge ? r_rd_data : r_val;
    assign gap_abs = sub_a - sub_b;

    assign out_free   = ~r_out_valid | i_out_ready;
    assign span_ok    = (r_held >= CNT_W'(2));
    assign count_wide = {{CAP_W{1'b0}}, r_held};

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (full) begin
                        n_state = ST_OUT;
                    end else if (r_held == '0) begin
                        n_state = ST_UPD;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (r_idx == r_held - CNT_W'(1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: n_state = ST_UPD;
            ST_UPD:   n_state = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cap   <= CAP_RESET;
            r_held  <= '0;
            r_idx   <= '0;
            r_cmp_v <= 1'b0;
            r_gap   <= '1;
            r_min   <= '0;
            r_max   <= '0;
        end else begin
            r_state <= n_state;
            r_cmp_v <= (r_state == ST_SCAN);
            if (cfg_wr) begin
                r_cap <= pwdata[CAP_W-1:0];
            end
            if (in_acc) begin
                r_idx <= '0;
            end else if (r_state == ST_SCAN) begin
                r_idx <= r_idx + CNT_W'(1);
            end
            if (r_cmp_v && (GAP_W'(gap_abs) < r_gap)) begin
                r_gap <= GAP_W'(gap_abs);
            end
            if (r_state == ST_UPD) begin
                r_held <= r_held + CNT_W'(1);
                if (r_held == '0) begin
                    r_min <= r_val;
                    r_max <= r_val;
                end else begin
                    if (r_val < r_min) begin
                        r_min <= r_val;
                    end
                    if (r_val > r_max) begin
                        r_max <= r_val;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_val    <= i_value;
            r_reject <= full;
        end
    end

    // number array: one read port for the scan, one write port for the add
    always_ff @(posedge i_clk) begin
        if (r_state == ST_SCAN) begin
            r_rd_data <= mem[r_idx[IDX_W-1:0]];
        end
        if (r_state == ST_UPD) begin
            mem[r_held[IDX_W-1:0]] <= r_val;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_OUT) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_OUT) && out_free) begin
            r_out_status     <= r_reject ? STATUS_FULL : STATUS_OK;
            r_out_count      <= count_wide[CAP_W-1:0];
            r_out_span_valid <= span_ok;
            r_out_short      <= span_ok ? r_gap[DATA_W-1:0] : '0;
            r_out_long       <= span_ok ? DATA_W'(r_max - r_min) : '0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_count         = r_out_count;
    assign o_span_valid    = r_out_span_valid;
    assign o_shortest_span = r_out_short;
    assign o_longest_span  = r_out_long;

    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= CNT_W'(MAX_COUNT))
        else $error("held count above array depth");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_idx < r_held))
        else $error("scan index beyond held numbers");

    a_held_moves_on_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held != $past(r_held)) |-> ($past(r_state) == ST_UPD))
        else $error("held count changed outside an add");

    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held != '0) |-> (r_min <= r_max))
        else $error("minimum above maximum");

endmodule

>>> tb/sv/tb_bounded_set_span_tracker_core.sv
`timescale 1ns / 1ps

module tb_bounded_set_span_tracker_core;
    import bsst_pkg::*;

    localparam int STALL_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 300;
    localparam int TARGET_WORDS = 800;

    localparam logic [APB_AW-1:0] CAPACITY_ADDR = {REG_CAPACITY, 2'b00};
    localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    typedef struct packed {
        logic              status;
        logic [CAP_W-1:0]  count;
        logic              span_valid;
        logic [DATA_W-1:0] shortest;
        logic [DATA_W-1:0] longest;
    } span_word_t;

    // Tracks the held set and predicts the result word for each accepted input.
    class span_board;
        logic [CAP_W-1:0]         capacity;
        logic signed [DATA_W-1:0] held[$];
        logic signed [DATA_W-1:0] lo;
        logic signed [DATA_W-1:0] hi;
        logic [GAP_W-1:0]         best_gap;
        span_word_t               pending[$];
        int                       errors;

        function new();
            capacity = CAP_RESET;
            lo       = '0;
            hi       = '0;
            best_gap = '1;
            errors   = 0;
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 10)
                $display("%s", msg);
        endfunction

        function void add_value(logic signed [DATA_W-1:0] v);
            int         lim;
            longint     d;
            span_word_t w;
            lim = (capacity > MAX_COUNT) ? MAX_COUNT : int'(capacity);
            if (held.size() >= lim) begin
                w.status = STATUS_FULL;
            end else begin
                w.status = STATUS_OK;
                foreach (held[k]) begin
                    d = longint'(v) - longint'(held[k]);
                    if (d < 0)
                        d = -d;
                    if (GAP_W'(d) < best_gap)
                        best_gap = GAP_W'(d);
                end
                if (held.size() == 0) begin
                    lo = v;
                    hi = v;
                end else begin
                    if (v < lo)
                        lo = v;
                    if (v > hi)
                        hi = v;
                end
                held.insert(held.size(), v);
            end
            w.count = CAP_W'(held.size());
            if (held.size() >= 2) begin
                w.span_valid = 1'b1;
                w.shortest   = best_gap[DATA_W-1:0];
                w.longest    = DATA_W'(longint'(hi) - longint'(lo));
            end else begin
                w.span_valid = 1'b0;
                w.shortest   = '0;
                w.longest    = '0;
            end
            pending.insert(pending.size(), w);
        endfunction

        function void check_word(span_word_t got);
            span_word_t exp;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result word: count %0d status %0d",
                                 got.count, got.status));
                return;
            end
            exp = pending.pop_front();
            if (got.status !== exp.status || got.count !== exp.count ||
                got.span_valid !== exp.span_valid || got.shortest !== exp.shortest ||
                got.longest !== exp.longest)
                report($sformatf({"mismatch (exp/act): status %0d/%0d count %0d/%0d ",
                                  "span_valid %0d/%0d shortest %h/%h longest %h/%h"},
                                 exp.status, got.status, exp.count, got.count,
                                 exp.span_valid, got.span_valid, exp.shortest, got.shortest,
                                 exp.longest, got.longest));
        endfunction

        function void check_leftovers();
            if (pending.size() != 0)
                report($sformatf("%0d result words never arrived", pending.size()));
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_ready;
    logic signed [DATA_W-1:0] i_value = '0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic                     o_status;
    logic [CAP_W-1:0]         o_count;
    logic                     o_span_valid;
    logic [DATA_W-1:0]        o_shortest_span;
    logic [DATA_W-1:0]        o_longest_span;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [APB_AW-1:0]        paddr = '0;
    logic [APB_DW-1:0]        pwdata = '0;
    logic [APB_DW-1:0]        prdata;
    logic                     pready;

    span_board   board;
    logic        in_fire_q = 1'b0;
    logic        out_fire_q = 1'b0;
    logic        hold_off = 1'b0;
    bit          press_go = 1'b0;
    bit          tx_idle = 1'b1;
    bit          rx_idle = 1'b1;
    int unsigned rx_wait = 0;
    int          stall = 0;
    int          sent = 0;

    always #1 i_clk = ~i_clk;

    bounded_set_span_tracker_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_value         (i_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_count         (o_count),
        .o_span_valid    (o_span_valid),
        .o_shortest_span (o_shortest_span),
        .o_longest_span  (o_longest_span),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // monitor, predictor hookup and watchdog
    always @(posedge i_clk) begin
        in_fire_q  <= i_rst_n && i_in_valid && o_in_ready;
        out_fire_q <= i_rst_n && o_out_valid && i_out_ready;
        if (i_rst_n) begin
            if (psel && penable && pwrite && pready && paddr == CAPACITY_ADDR)
                board.capacity = pwdata[CAP_W-1:0];
            if (i_in_valid && o_in_ready)
                board.add_value(i_value);
            if (o_out_valid && i_out_ready)
                board.check_word({o_status, o_count, o_span_valid,
                                  o_shortest_span, o_longest_span});
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                stall = 0;
            else
                stall = stall + 1;
            if (stall >= STALL_LIMIT) begin
                $display("** bounded_set_span_tracker_core: FAILED **");
                $finish;
            end
        end
    end

    // result side: random wait after each word when rx_idle is set, plus the long hold-off
    always @(negedge i_clk) begin
        if (out_fire_q)
            rx_wait = rx_idle ? $urandom_range(0, 14) : 0;
        if (rx_wait > 0) begin
            rx_wait = rx_wait - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= i_rst_n && !hold_off;
        end
    end

    // long receiver stall so the block backs up and drops o_in_ready
    initial begin
        wait (press_go);
        @(negedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge i_clk);
        hold_off <= 1'b0;
    end

    task automatic send_value(input logic signed [DATA_W-1:0] v);
        int unsigned gap;
        gap = tx_idle ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_value    <= v;
        sent++;
        @(negedge i_clk);
        while (!in_fire_q) @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_capacity(input int unsigned cap);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAPACITY_ADDR;
        pwdata  <= APB_DW'(cap);
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // range widens as the set grows so both spans keep moving; some near-neighbors
    function automatic logic signed [DATA_W-1:0] pick_value(int n);
        int unsigned k;
        int unsigned r;
        k = 8 + n / 2;
        if (k > 30)
            k = 30;
        if (n > 0 && $urandom_range(0, 7) == 0)
            return board.held[$urandom_range(0, n - 1)] + int'($urandom_range(1, 5));
        r = $urandom_range(0, (32'd1 << (k + 1)) - 1);
        return int'(r) - int'(32'd1 << k);
    endfunction

    initial begin
        int unsigned cap;
        board = new();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // zero capacity: everything rejected on an empty set
        set_capacity(0);
        send_value(VAL_MAX);
        send_value(VAL_MIN);
        // single number: no span yet, then full
        set_capacity(1);
        send_value('0);
        send_value('1);

        // grow the set in small steps, sometimes dropping capacity below the count
        while (board.held.size() < 56) begin
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 3) == 0)
                cap = $urandom_range(0, board.held.size());
            else
                cap = board.held.size() + $urandom_range(1, 6);
            set_capacity(cap);
            // hold-off starts while this batch is still being offered
            if (board.held.size() >= 20)
                press_go = 1'b1;
            repeat ($urandom_range(6, 16)) send_value(pick_value(board.held.size()));
        end

        // full-scale extremes and an equal pair
        set_capacity(MAX_COUNT);
        send_value(VAL_MIN);
        send_value(VAL_MAX);
        send_value(VAL_MAX);

        // capacity above the hardware limit saturates at MAX_COUNT
        set_capacity(127);
        while (board.held.size() < MAX_COUNT)
            send_value(pick_value(board.held.size()));

        // set is full now: rejects under assorted capacities, full-range words
        while (sent < TARGET_WORDS) begin
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 3))
                0:       cap = 0;
                1:       cap = 127;
                2:       cap = MAX_COUNT;
                default: cap = $urandom_range(0, 127);
            endcase
            set_capacity(cap);
            repeat ($urandom_range(20, 40)) send_value($urandom());
        end

        drain();
        repeat (80) @(posedge i_clk);
        board.check_leftovers();
        if (board.errors == 0)
            $display("** bounded_set_span_tracker_core: PASSED **");
        else
            $display("** bounded_set_span_tracker_core: FAILED **");
        $finish;
    end

endmodule
